// ===== hw/rtl/spm_pkg.sv =====
// Package: constants, codes, types and the default-action table of the signal unit.
package spm_pkg;

  // Number of signals handled by the unit (32..64)
  localparam int unsigned SigCount = 64;
  localparam int unsigned SigIdxW  = $clog2(SigCount);

  localparam int unsigned CmdW     = 3;
  localparam int unsigned SigNumW  = 8;
  localparam int unsigned SigOutW  = 7;
  localparam int unsigned WordW    = 64;
  localparam int unsigned ActW     = 3;

  localparam logic [SigNumW-1:0] SigKill = SigNumW'(9);
  localparam logic [SigNumW-1:0] SigStop = SigNumW'(19);

  typedef logic [SigCount-1:0] sig_set_t;

  localparam sig_set_t OneBit      = sig_set_t'(1);
  localparam sig_set_t Unblockable = (OneBit << (SigKill - 1)) | (OneBit << (SigStop - 1));

  // Status codes
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusInval = 1'b1;

  typedef enum logic [CmdW-1:0] {
    CMD_SEND    = 3'd0,
    CMD_HANDLER = 3'd1,
    CMD_BLOCK   = 3'd2,
    CMD_UNBLOCK = 3'd3,
    CMD_SETMASK = 3'd4,
    CMD_DELIVER = 3'd5
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE    = 3'd0,
    ACT_IGNORED = 3'd1,
    ACT_TERM    = 3'd2,
    ACT_STOP    = 3'd3,
    ACT_CONT    = 3'd4,
    ACT_DEF_IGN = 3'd5,
    ACT_HANDLER = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FETCH
  } state_e;

  // Handler words with a special meaning
  localparam logic [WordW-1:0] HandlerDefault = WordW'(0);
  localparam logic [WordW-1:0] HandlerIgnore  = WordW'(1);

  // Registered response
  typedef struct packed {
    logic               status;
    action_e            action;
    logic [SigOutW-1:0] sig;
    logic [WordW-1:0]   handler;
    logic [WordW-1:0]   old;
    logic               last;
  } rsp_t;

  // Default disposition per signal number (Linux numbering)
  function automatic action_e default_action(input logic [SigOutW-1:0] sig);
    action_e act;
    case (sig)
      7'd3, 7'd4, 7'd6, 7'd7, 7'd8, 7'd9, 7'd11, 7'd15: act = ACT_TERM;
      7'd19, 7'd20, 7'd21, 7'd22:                      act = ACT_STOP;
      7'd18:                                           act = ACT_CONT;
      default:                                         act = ACT_DEF_IGN;
    endcase
    return act;
  endfunction

endpackage

// ===== hw/rtl/spm_req_if.sv =====
// Interface: request channel of the signal unit.
interface spm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  signal_number;
  logic        has_value;
  logic [63:0] handler_value;
  logic [63:0] mask_value;

  modport source (
    output valid, cmd, signal_number, has_value, handler_value, mask_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, signal_number, has_value, handler_value, mask_value,
    output ready
  );
endinterface

// ===== hw/rtl/spm_rsp_if.sv =====
// Interface: response channel of the signal unit.
interface spm_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [2:0]  action;
  logic [6:0]  signal_out;
  logic [63:0] handler_out;
  logic [63:0] old_value;
  logic        last;

  modport source (
    output valid, status, action, signal_out, handler_out, old_value, last,
    input  ready
  );
  modport sink (
    input  valid, status, action, signal_out, handler_out, old_value, last,
    output ready
  );
endinterface

// ===== hw/rtl/spm_handler_mem.sv =====
// Handler store: synchronous RAM with registered read and per-entry valid bits.
module spm_handler_mem
  import spm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [SigIdxW-1:0] rd_addr_i,
  output logic [WordW-1:0]   rd_data_o,
  input  logic               wr_en_i,
  input  logic [SigIdxW-1:0] wr_addr_i,
  input  logic [WordW-1:0]   wr_data_i
);

  logic [WordW-1:0] mem [SigCount];
  logic [SigCount-1:0] valid_q;
  logic [WordW-1:0] rd_data_q;
  logic             rd_valid_q;

  // Valid bits: an entry never written reads as the default handler
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Array write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : HandlerDefault;

endmodule

// ===== hw/rtl/spm_find_first.sv =====
// Lowest-set-bit finder over a signal set, two levels of eight.
module spm_find_first
  import spm_pkg::*;
(
  input  sig_set_t           vec_i,
  output logic               found_o,
  output logic [SigIdxW-1:0] idx_o
);

  logic [63:0] padded;
  logic [7:0]  grp_any;
  logic [2:0]  grp_sel;
  logic [7:0]  grp_bits;
  logic [2:0]  bit_sel;

  always_comb begin
    padded = 64'(vec_i);
    for (int g = 0; g < 8; g++) begin
      grp_any[g] = |padded[g*8 +: 8];
    end
    // Pick lowest nonempty group
    grp_sel = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = 3'(g);
      end
    end
    grp_bits = padded[grp_sel*8 +: 8];
    // Pick lowest bit inside it
    bit_sel = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = 3'(b);
      end
    end
  end

  assign found_o = |grp_any;
  assign idx_o   = SigIdxW'({grp_sel, bit_sel});

endmodule

// ===== hw/rtl/signal_pending_mask_controller_core.sv =====
// Top level: signal pending/mask unit with handler RAM and command sequencer.
//
//  Channel | Dir | Handshake   | Payload
//  req_i   | in  | valid/ready | cmd, signal_number, has_value, handler_value, mask_value
//  rsp_o   | out | valid/ready | status, action, signal_out, handler_out, old_value, last
//
// Every command except deliver is accepted with a handler RAM read, then executed.
// Deliver is accepted, then each taken signal goes through find-first + RAM read, then report;
// when nothing is taken, the scan reports that at once.
// Reset clears pending set, blocked mask and the RAM valid bits at once; no sweep follows.
// A full response register stalls execution; a new request is taken while the last
// response of the previous command still waits.
module signal_pending_mask_controller_core
  import spm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  spm_req_if.sink   req_i,
  spm_rsp_if.source rsp_o
);

  state_e state_q, state_d;

  // Latched request
  logic [CmdW-1:0]    cmd_q;
  logic [SigNumW-1:0] sig_q;
  logic               has_q;
  logic [WordW-1:0]   hval_q;
  logic [WordW-1:0]   mval_q;

  // Signal state
  sig_set_t pend_q, pend_d;
  sig_set_t blk_q, blk_d;

  // Deliver scan index
  logic [SigIdxW-1:0] scan_idx_q, scan_idx_d;

  // Response register
  rsp_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic accept;
  logic out_free;
  logic sig_ok;
  logic [SigIdxW-1:0] sig_idx;

  sig_set_t           elig;
  logic               ff_found;
  logic [SigIdxW-1:0] ff_idx;

  logic               rd_en;
  logic [SigIdxW-1:0] rd_addr;
  logic [WordW-1:0]   rd_data;
  logic               wr_en;

  sig_set_t           mval_set;
  sig_set_t           nb;
  sig_set_t           scan_bit;
  logic [SigOutW-1:0] scan_sig;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign sig_ok   = (sig_q >= SigNumW'(1)) && (sig_q <= SigNumW'(SigCount));
  assign sig_idx  = SigIdxW'(sig_q - SigNumW'(1));
  assign elig     = pend_q & ~blk_q;
  assign mval_set = mval_q[SigCount-1:0];
  assign scan_bit = OneBit << scan_idx_q;
  assign scan_sig = SigOutW'(scan_idx_q) + SigOutW'(1);

  spm_find_first u_find (
    .vec_i   (elig),
    .found_o (ff_found),
    .idx_o   (ff_idx)
  );

  spm_handler_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (sig_idx),
    .wr_data_i (hval_q)
  );

  // Next-state and datapath control
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    blk_d       = blk_q;
    scan_idx_d  = scan_idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    rd_en       = 1'b0;
    rd_addr     = SigIdxW'(req_i.signal_number - SigNumW'(1));
    wr_en       = 1'b0;
    nb          = blk_q;
    req_i.ready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_en   = 1'b1;
          state_d = (cmd_e'(req_i.cmd) == CMD_DELIVER) ? ST_SCAN : ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{status: StatusOk, action: ACT_NONE, sig: '0,
                          handler: '0, old: '0, last: 1'b1};
          state_d     = ST_IDLE;
          case (cmd_e'(cmd_q))
            CMD_SEND: begin
              if (!sig_ok) begin
                out_d.status = StatusInval;
              end else if (sig_q == SigKill) begin
                out_d.action = ACT_TERM;
                out_d.sig    = SigOutW'(sig_q);
              end else if (sig_q == SigStop) begin
                out_d.action = ACT_STOP;
                out_d.sig    = SigOutW'(sig_q);
              end else begin
                pend_d = pend_q | (OneBit << sig_idx);
              end
            end
            CMD_HANDLER: begin
              if (!sig_ok || sig_q == SigKill || sig_q == SigStop) begin
                out_d.status = StatusInval;
              end else begin
                out_d.old = rd_data;
                wr_en     = has_q;
              end
            end
            CMD_BLOCK, CMD_UNBLOCK, CMD_SETMASK: begin
              out_d.old = WordW'(blk_q);
              if (cmd_e'(cmd_q) == CMD_BLOCK) begin
                nb = blk_q | mval_set;
              end else if (cmd_e'(cmd_q) == CMD_UNBLOCK) begin
                nb = blk_q & ~mval_set;
              end else begin
                nb = mval_set;
              end
              if (has_q) begin
                blk_d = nb & ~Unblockable;
              end
            end
            default: begin
              out_d.status = StatusInval;
            end
          endcase
        end
      end

      // Find the next deliverable signal and fetch its handler, or report that none is taken
      ST_SCAN: begin
        if (ff_found) begin
          rd_en      = 1'b1;
          rd_addr    = ff_idx;
          scan_idx_d = ff_idx;
          state_d    = ST_FETCH;
        end else if (out_free) begin
          // Nothing taken at all
          out_valid_d = 1'b1;
          out_d       = '{status: StatusOk, action: ACT_NONE, sig: '0,
                          handler: '0, old: '0, last: 1'b1};
          state_d     = ST_IDLE;
        end
      end

      // Report one taken signal
      ST_FETCH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          pend_d      = pend_q & ~scan_bit;
          out_d       = '{status: StatusOk, action: ACT_NONE, sig: scan_sig,
                          handler: '0, old: '0, last: 1'b0};
          if (rd_data == HandlerIgnore) begin
            out_d.action = ACT_IGNORED;
          end else if (rd_data == HandlerDefault) begin
            out_d.action = default_action(scan_sig);
          end else begin
            out_d.action  = ACT_HANDLER;
            out_d.handler = rd_data;
          end
          out_d.last = (out_d.action == ACT_HANDLER) || ((elig & ~scan_bit) == '0);
          state_d    = out_d.last ? ST_IDLE : ST_SCAN;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= '0;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      blk_q       <= blk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.cmd;
      sig_q  <= req_i.signal_number;
      has_q  <= req_i.has_value;
      hval_q <= req_i.handler_value;
      mval_q <= req_i.mask_value;
    end
    scan_idx_q <= scan_idx_d;
    out_q      <= out_d;
  end

  // Response port
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.action      = out_q.action;
  assign rsp_o.signal_out  = out_q.sig;
  assign rsp_o.handler_out = out_q.handler;
  assign rsp_o.old_value   = out_q.old;
  assign rsp_o.last        = out_q.last;

endmodule

// ===== test/tb_top.sv =====
// Testbench: signal pending/mask unit checked against a cycle-free predictor of its commands.
`timescale 1ns / 100ps

module tb_top
  import spm_pkg::*;
();

  // Reserved command codes the unit must refuse
  localparam logic [CmdW-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD_HI = 3'd7;

  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned TailCycles   = 40;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned RandomItems  = 285;
  localparam int unsigned MaxPrinted   = 60;

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [SigNumW-1:0] sig;
    logic               has;
    logic [WordW-1:0]   hval;
    logic [WordW-1:0]   mval;
  } sig_cmd_t;

  logic clk_i;
  logic rst_ni;

  spm_req_if req_bus ();
  spm_rsp_if rsp_bus ();

  signal_pending_mask_controller_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Predicted unit state
  sig_set_t         pend_set;
  sig_set_t         blk_mask;
  logic [WordW-1:0] handler_words [SigCount];

  sig_cmd_t cmd_queue [$];
  rsp_t     due_responses [$];

  int  err_cnt;
  int  cycle_cnt;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  bit  hold_go;
  bit  hold_used;
  logic req_fire;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Known values on every input from time zero
  initial begin
    req_bus.valid         = 1'b0;
    req_bus.cmd           = '0;
    req_bus.signal_number = '0;
    req_bus.has_value     = 1'b0;
    req_bus.handler_value = '0;
    req_bus.mask_value    = '0;
    rsp_bus.ready         = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    if (err_cnt < MaxPrinted) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    end
    err_cnt++;
  endtask

  // Default disposition of a signal left at the default handler
  function automatic action_e default_disposition(input int unsigned s);
    action_e act;
    case (s)
      3, 4, 6, 7, 8, 9, 11, 15: act = ACT_TERM;
      19, 20, 21, 22:           act = ACT_STOP;
      18:                       act = ACT_CONT;
      default:                  act = ACT_DEF_IGN;
    endcase
    return act;
  endfunction

  function automatic rsp_t mk_rsp(input logic status, input action_e act,
                                  input int unsigned s, input logic [WordW-1:0] h,
                                  input logic [WordW-1:0] old);
    rsp_t r;
    r.status  = status;
    r.action  = act;
    r.sig     = SigOutW'(s);
    r.handler = h;
    r.old     = old;
    r.last    = 1'b0;
    return r;
  endfunction

  // Apply one accepted request to the predicted state and queue its responses
  task automatic apply_signal_cmd(input sig_cmd_t c);
    rsp_t             batch [$];
    logic [WordW-1:0] old;
    logic [WordW-1:0] hw;
    sig_set_t         nb;
    int unsigned      s;
    int unsigned      idx;
    bit               sig_ok;
    bit               stop_scan;
    s      = c.sig;
    sig_ok = (s >= 1) && (s <= SigCount);
    idx    = sig_ok ? s - 1 : 0;
    case (c.cmd)
      CMD_SEND: begin
        if (!sig_ok) begin
          batch.push_back(mk_rsp(StatusInval, ACT_NONE, 0, '0, '0));
        end else if (c.sig == SigKill) begin
          batch.push_back(mk_rsp(StatusOk, ACT_TERM, s, '0, '0));
        end else if (c.sig == SigStop) begin
          batch.push_back(mk_rsp(StatusOk, ACT_STOP, s, '0, '0));
        end else begin
          pend_set[idx] = 1'b1;
          batch.push_back(mk_rsp(StatusOk, ACT_NONE, 0, '0, '0));
        end
      end
      CMD_HANDLER: begin
        if (!sig_ok || c.sig == SigKill || c.sig == SigStop) begin
          batch.push_back(mk_rsp(StatusInval, ACT_NONE, 0, '0, '0));
        end else begin
          old = handler_words[idx];
          if (c.has) handler_words[idx] = c.hval;
          batch.push_back(mk_rsp(StatusOk, ACT_NONE, 0, '0, old));
        end
      end
      CMD_BLOCK, CMD_UNBLOCK, CMD_SETMASK: begin
        old = blk_mask;
        if (c.has) begin
          if (c.cmd == CMD_BLOCK)        nb = blk_mask | c.mval;
          else if (c.cmd == CMD_UNBLOCK) nb = blk_mask & ~c.mval;
          else                           nb = c.mval;
          blk_mask = nb & ~Unblockable;
        end
        batch.push_back(mk_rsp(StatusOk, ACT_NONE, 0, '0, old));
      end
      CMD_DELIVER: begin
        // Ascending scan, ends after the first custom handler
        stop_scan = 1'b0;
        for (int unsigned n = 1; n <= SigCount; n++) begin
          if (!stop_scan && pend_set[n-1] && !blk_mask[n-1]) begin
            pend_set[n-1] = 1'b0;
            hw = handler_words[n-1];
            if (hw == HandlerIgnore) begin
              batch.push_back(mk_rsp(StatusOk, ACT_IGNORED, n, '0, '0));
            end else if (hw == HandlerDefault) begin
              batch.push_back(mk_rsp(StatusOk, default_disposition(n), n, '0, '0));
            end else begin
              batch.push_back(mk_rsp(StatusOk, ACT_HANDLER, n, hw, '0));
              stop_scan = 1'b1;
            end
          end
        end
        if (batch.size() == 0) batch.push_back(mk_rsp(StatusOk, ACT_NONE, 0, '0, '0));
      end
      default: begin
        batch.push_back(mk_rsp(StatusInval, ACT_NONE, 0, '0, '0));
      end
    endcase
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) due_responses.push_back(batch[i]);
  endtask

  // Compare one accepted response with the oldest prediction
  task automatic check_response();
    rsp_t want;
    if (due_responses.size() == 0) begin
      report_mismatch("unexpected response", 64'(rsp_bus.action), '0);
    end else begin
      want = due_responses.pop_front();
      if (rsp_bus.status !== want.status)
        report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
      if (rsp_bus.action !== want.action)
        report_mismatch("action", 64'(rsp_bus.action), 64'(want.action));
      if (rsp_bus.signal_out !== want.sig)
        report_mismatch("signal_out", 64'(rsp_bus.signal_out), 64'(want.sig));
      if (rsp_bus.handler_out !== want.handler)
        report_mismatch("handler_out", rsp_bus.handler_out, want.handler);
      if (rsp_bus.old_value !== want.old)
        report_mismatch("old_value", rsp_bus.old_value, want.old);
      if (rsp_bus.last !== want.last)
        report_mismatch("last", 64'(rsp_bus.last), 64'(want.last));
    end
  endtask

  // Monitor: sample both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_bus.valid && req_bus.ready;
      if (rsp_bus.valid && rsp_bus.ready) check_response();
      if (req_bus.valid && req_bus.ready) begin
        apply_signal_cmd({req_bus.cmd, req_bus.signal_number, req_bus.has_value,
                          req_bus.handler_value, req_bus.mask_value});
      end
    end
  end

  // Request driver: bursts of requests with random gaps, valid held until taken
  always @(negedge clk_i) begin
    sig_cmd_t nxt;
    logic     drive_v;
    if (rst_ni) begin
      if (req_fire) begin
        nxt = cmd_queue.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
        end
      end
      drive_v = 1'b0;
      if (req_bus.valid && !req_fire) begin
        drive_v = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_queue.size() > 0) begin
        nxt                    = cmd_queue[0];
        drive_v                = 1'b1;
        req_bus.cmd           <= nxt.cmd;
        req_bus.signal_number <= nxt.sig;
        req_bus.has_value     <= nxt.has;
        req_bus.handler_value <= nxt.hval;
        req_bus.mask_value    <= nxt.mval;
      end
      req_bus.valid <= drive_v;
    end
  end

  // Long receiver hold-off, started once by the stimulus
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_left <= LongHold;
      hold_used <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response ready: the stall pattern steps through four modes in turn, chosen from the cycle counter
  always @(negedge clk_i) begin
    logic rdy;
    case ((cycle_cnt / 128) % 4)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(0, 3) != 0);
      2:       rdy = ($urandom_range(0, 2) == 0);
      default: rdy = ((cycle_cnt % 7) < 3);
    endcase
    if (!rst_ni || hold_left > 0) rdy = 1'b0;
    rsp_bus.ready <= rdy;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [SigNumW-1:0] pick_signal();
    if ($urandom_range(0, 99) < 88) return SigNumW'($urandom_range(1, SigCount));
    return SigNumW'($urandom_range(0, 255));
  endfunction

  function automatic logic [WordW-1:0] pick_handler();
    case ($urandom_range(0, 2))
      0:       return HandlerDefault;
      1:       return HandlerIgnore;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [WordW-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0, 1:    return rand_word();
      2, 3:    return OneBit << $urandom_range(0, SigCount - 1);
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  task automatic push_cmd(input logic [CmdW-1:0] cmd, input logic [SigNumW-1:0] sig,
                          input logic has, input logic [WordW-1:0] hval,
                          input logic [WordW-1:0] mval);
    sig_cmd_t c;
    c.cmd  = cmd;
    c.sig  = sig;
    c.has  = has;
    c.hval = hval;
    c.mval = mval;
    cmd_queue.push_back(c);
  endtask

  // Random stimulus: mostly set-up / send / deliver groups, some noise
  task automatic push_random(input int unsigned count);
    int unsigned made;
    int unsigned k;
    logic [CmdW-1:0] mcmd;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_cmd(CmdW'($urandom_range(0, 7)), SigNumW'($urandom_range(0, 255)),
                 1'($urandom), rand_word(), rand_word());
        made++;
      end else begin
        k = $urandom_range(0, 2);
        repeat (k) begin
          if ($urandom_range(0, 1) == 0) begin
            push_cmd(CMD_HANDLER, pick_signal(), ($urandom_range(0, 4) != 0),
                     pick_handler(), rand_word());
          end else begin
            case ($urandom_range(0, 2))
              0:       mcmd = CMD_BLOCK;
              1:       mcmd = CMD_UNBLOCK;
              default: mcmd = CMD_SETMASK;
            endcase
            push_cmd(mcmd, SigNumW'($urandom_range(0, 255)), ($urandom_range(0, 4) != 0),
                     rand_word(), pick_mask());
          end
          made++;
        end
        k = $urandom_range(2, 6);
        repeat (k) begin
          push_cmd(CMD_SEND, pick_signal(), 1'($urandom), rand_word(), rand_word());
          made++;
        end
        k = $urandom_range(1, 2);
        repeat (k) begin
          push_cmd(CMD_DELIVER, SigNumW'($urandom_range(0, 255)), 1'($urandom),
                   rand_word(), rand_word());
          made++;
        end
      end
    end
  endtask

  // Sender pause: wait until every request is taken and answered
  task automatic wait_drained();
    while (cmd_queue.size() != 0 || req_bus.valid || due_responses.size() != 0)
      @(posedge clk_i);
  endtask

  // Stimulus sequence and end of run
  initial begin
    err_cnt    = 0;
    cycle_cnt  = 0;
    burst_left = 4;
    gap_left   = 0;
    hold_left  = 0;
    hold_go    = 1'b0;
    hold_used  = 1'b0;
    pend_set   = '0;
    blk_mask   = '0;
    foreach (handler_words[i]) handler_words[i] = HandlerDefault;

    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bad numbers, kill/stop, handler refusals, masks, scans
    push_cmd(CMD_SEND, 8'd0, 1'b0, '0, '0);
    push_cmd(CMD_SEND, 8'd255, 1'b1, '1, '1);
    push_cmd(CMD_SEND, 8'd65, 1'b0, '0, '0);
    push_cmd(CMD_SEND, SigKill, 1'b0, '0, '0);
    push_cmd(CMD_SEND, SigStop, 1'b0, '0, '0);
    push_cmd(CMD_HANDLER, SigKill, 1'b1, 64'h1234, '0);
    push_cmd(CMD_HANDLER, SigStop, 1'b1, 64'h1234, '0);
    push_cmd(CMD_HANDLER, 8'd0, 1'b1, 64'h1234, '0);
    push_cmd(CMD_HANDLER, 8'd64, 1'b1, '1, '0);
    push_cmd(CMD_HANDLER, 8'd64, 1'b0, '0, '0);
    push_cmd(CMD_HANDLER, 8'd2, 1'b1, HandlerIgnore, '0);
    push_cmd(CMD_HANDLER, 8'd5, 1'b1, 64'h0000_0000_0000_1000, '0);
    push_cmd(CMD_BLOCK, 8'd0, 1'b1, '0, '1);
    push_cmd(CMD_SEND, 8'd2, 1'b0, '0, '0);
    push_cmd(CMD_SEND, 8'd3, 1'b0, '0, '0);
    push_cmd(CMD_SEND, 8'd5, 1'b0, '0, '0);
    push_cmd(CMD_SEND, 8'd18, 1'b0, '0, '0);
    push_cmd(CMD_SEND, 8'd64, 1'b0, '0, '0);
    push_cmd(CMD_DELIVER, 8'd0, 1'b0, '0, '0);
    push_cmd(CMD_UNBLOCK, 8'd0, 1'b1, '0, '1);
    push_cmd(CMD_DELIVER, 8'd0, 1'b0, '0, '0);
    push_cmd(CMD_DELIVER, 8'd0, 1'b0, '0, '0);
    push_cmd(CMD_SETMASK, 8'd0, 1'b0, '0, '1);
    push_cmd(CMD_RSVD_LO, 8'd1, 1'b1, '1, '1);
    push_cmd(CMD_RSVD_HI, 8'd1, 1'b1, '1, '1);
    wait_drained();

    // First random half with a long receiver stall
    push_random(RandomItems / 2);
    hold_go = 1'b1;
    wait_drained();

    // Second random half
    push_random(RandomItems - RandomItems / 2);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (due_responses.size() != 0)
      report_mismatch("responses still outstanding", 64'(due_responses.size()), '0);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
